[rtl/ccs_pkg.sv]
// ccs_pkg: shared types, codes and constants for the clamp cell step sequencer
// used by ccs_cfg_regs, ccs_step_core and clamp_cell_step_sequencer; no dependencies
package ccs_pkg;

    // configuration port address width (five 32-bit registers at 4*i)
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes on paddr[4:2]
    localparam logic [2:0] REG_STEP_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_DWELL        = 3'd1;
    localparam logic [2:0] REG_TICK         = 3'd2;
    localparam logic [2:0] REG_PARTS_GOAL   = 3'd3;
    localparam logic [2:0] REG_MOTOR_RATE   = 3'd4;

    // register reset values
    localparam logic [31:0] RST_STEP_TIMEOUT = 32'd5000;
    localparam logic [15:0] RST_DWELL        = 16'd1000;
    localparam logic [15:0] RST_TICK         = 16'd100;
    localparam logic [15:0] RST_PARTS_GOAL   = 16'd0;
    localparam logic [15:0] RST_MOTOR_RATE   = 16'd0;

    // stack lamp patterns, 2 bits per lamp from red upwards
    localparam logic [9:0] LAMP_OFF     = 10'h000;
    localparam logic [9:0] LAMP_FAULT   = 10'h202;
    localparam logic [9:0] LAMP_RUN     = 10'h010;
    localparam logic [9:0] LAMP_PROCESS = 10'h014;
    localparam logic [9:0] LAMP_DONE    = 10'h040;

    localparam logic [15:0] PARTS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_TIMEOUT = 2'd1,
        FAULT_MOTOR   = 2'd2,
        FAULT_CLAMP   = 2'd3
    } t_fault;

    typedef enum logic [1:0] {
        CLAMP_NONE    = 2'd0,
        CLAMP_EXTEND  = 2'd1,
        CLAMP_RETRACT = 2'd2
    } t_clamp;

    typedef enum logic [3:0] {
        ST_IDLE         = 4'd0,
        ST_MOTOR_START  = 4'd1,
        ST_WAIT_SPEED   = 4'd2,
        ST_CLAMP_EXTEND = 4'd3,
        ST_WAIT_EXTEND  = 4'd4,
        ST_DWELL        = 4'd5,
        ST_RETRACT      = 4'd6,
        ST_WAIT_RETRACT = 4'd7,
        ST_COUNT        = 4'd8
    } t_step;

    typedef struct packed {
        logic [31:0] wait_limit_ms;
        logic [15:0] dwell_ms;
        logic [15:0] tick_ms;
        logic [15:0] parts_goal;
        logic [15:0] motor_rate;
    } t_cfg;

    typedef struct packed {
        t_cmd command;
        logic motor_spun_up;
        logic clamp_is_extended;
        logic clamp_is_retracted;
        logic motor_ack_ok;
        logic clamp_ack_ok;
    } t_item;

    typedef struct packed {
        logic        accepted;
        t_step       step_now;
        logic        is_running;
        logic        is_complete;
        logic        is_faulted;
        t_fault      fault_cause;
        logic [15:0] parts_done;
        logic        lamp_valid;
        logic [9:0]  lamp_pattern;
        logic        motor_cmd_valid;
        logic [15:0] motor_rate_cmd;
        t_clamp      clamp_cmd;
    } t_result;

endpackage

[rtl/clamp_cell_step_sequencer.sv]
// clamp_cell_step_sequencer: top level with input register, step core and result register
// depends on ccs_pkg, ccs_cfg_regs and ccs_step_core
//
// One command transfer gives one status transfer. The block takes a new item
// every clock while the output side is ready: the item lands in an input
// register, the step core updates the sequencer state and forms the status
// combinationally, and the status waits in an output register. Configuration
// must be written through the APB-style port only while the block is idle;
// the block itself does not enforce this. There is no clearing pass after reset.
module clamp_cell_step_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ccs_pkg::ADDR_W-1:0] paddr,
    input  logic [ccs_pkg::DATA_W-1:0] pwdata,
    output logic [ccs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_command,
    input  logic                       i_motor_spun_up,
    input  logic                       i_clamp_is_extended,
    input  logic                       i_clamp_is_retracted,
    input  logic                       i_motor_ack_ok,
    input  logic                       i_clamp_ack_ok,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_accepted,
    output logic [3:0]                 o_step_now,
    output logic                       o_is_running,
    output logic                       o_is_complete,
    output logic                       o_is_faulted,
    output logic [1:0]                 o_fault_cause,
    output logic [15:0]                o_parts_done,
    output logic                       o_lamp_valid,
    output logic [9:0]                 o_lamp_pattern,
    output logic                       o_motor_cmd_valid,
    output logic [15:0]                o_motor_rate_cmd,
    output logic [1:0]                 o_clamp_cmd
);

    ccs_pkg::t_cfg    cfg;
    ccs_pkg::t_result core_result;
    ccs_pkg::t_item   in_item;
    ccs_pkg::t_item   r_in_item;
    logic             r_in_valid;
    ccs_pkg::t_result r_out;
    logic             r_out_valid;
    logic             fire;

    ccs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pack the input fields
    always_comb begin
        in_item.command            = ccs_pkg::t_cmd'(i_command);
        in_item.motor_spun_up      = i_motor_spun_up;
        in_item.clamp_is_extended  = i_clamp_is_extended;
        in_item.clamp_is_retracted = i_clamp_is_retracted;
        in_item.motor_ack_ok       = i_motor_ack_ok;
        in_item.clamp_ack_ok       = i_clamp_ack_ok;
    end

    // item moves into the core when the result register is free or draining
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_item <= in_item;
        end
    end

    ccs_step_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    // unpack the result fields
    assign o_valid           = r_out_valid;
    assign o_accepted        = r_out.accepted;
    assign o_step_now        = r_out.step_now;
    assign o_is_running      = r_out.is_running;
    assign o_is_complete     = r_out.is_complete;
    assign o_is_faulted      = r_out.is_faulted;
    assign o_fault_cause     = r_out.fault_cause;
    assign o_parts_done      = r_out.parts_done;
    assign o_lamp_valid      = r_out.lamp_valid;
    assign o_lamp_pattern    = r_out.lamp_pattern;
    assign o_motor_cmd_valid = r_out.motor_cmd_valid;
    assign o_motor_rate_cmd  = r_out.motor_rate_cmd;
    assign o_clamp_cmd       = r_out.clamp_cmd;

endmodule

[rtl/ccs_cfg_regs.sv]
// ccs_cfg_regs: APB-style configuration registers of the sequencer
// depends on ccs_pkg
module ccs_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ccs_pkg::ADDR_W-1:0] paddr,
    input  logic [ccs_pkg::DATA_W-1:0] pwdata,
    output logic [ccs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ccs_pkg::t_cfg              o_cfg
);

    ccs_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ccs_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wait_limit_ms <= ccs_pkg::RST_STEP_TIMEOUT;
            r_cfg.dwell_ms      <= ccs_pkg::RST_DWELL;
            r_cfg.tick_ms       <= ccs_pkg::RST_TICK;
            r_cfg.parts_goal    <= ccs_pkg::RST_PARTS_GOAL;
            r_cfg.motor_rate    <= ccs_pkg::RST_MOTOR_RATE;
        end else if (wr_en) begin
            unique case (reg_idx)
                ccs_pkg::REG_STEP_TIMEOUT: r_cfg.wait_limit_ms <= pwdata;
                ccs_pkg::REG_DWELL:        r_cfg.dwell_ms      <= pwdata[15:0];
                ccs_pkg::REG_TICK:         r_cfg.tick_ms       <= pwdata[15:0];
                ccs_pkg::REG_PARTS_GOAL:   r_cfg.parts_goal    <= pwdata[15:0];
                ccs_pkg::REG_MOTOR_RATE:   r_cfg.motor_rate    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (reg_idx)
            ccs_pkg::REG_STEP_TIMEOUT: prdata = r_cfg.wait_limit_ms;
            ccs_pkg::REG_DWELL:        prdata = {16'd0, r_cfg.dwell_ms};
            ccs_pkg::REG_TICK:         prdata = {16'd0, r_cfg.tick_ms};
            ccs_pkg::REG_PARTS_GOAL:   prdata = {16'd0, r_cfg.parts_goal};
            ccs_pkg::REG_MOTOR_RATE:   prdata = {16'd0, r_cfg.motor_rate};
            default:                   prdata = '0;
        endcase
    end

endmodule

[rtl/ccs_step_core.sv]
// ccs_step_core: sequencer state registers and combinational step update
// depends on ccs_pkg
module ccs_step_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  ccs_pkg::t_item   i_item,
    input  ccs_pkg::t_cfg    i_cfg,
    output ccs_pkg::t_result o_result
);

    ccs_pkg::t_step  r_step,    n_step;
    logic            r_running, n_running;
    logic            r_complete, n_complete;
    logic            r_fault,   n_fault;
    ccs_pkg::t_fault r_code,    n_code;
    logic [31:0]     r_timer,   n_timer;
    logic [15:0]     r_parts,   n_parts;

    logic [32:0]     timer_sum;
    logic [31:0]     timer_inc;
    logic [15:0]     parts_inc;
    logic            fault_hit;
    ccs_pkg::t_fault fault_kind;
    logic            accepted;
    logic            lamp_v;
    logic [9:0]      lamp_p;
    logic            motor_v;
    logic [15:0]     motor_s;
    ccs_pkg::t_clamp clamp_c;

    // saturating step timer and parts count
    assign timer_sum = {1'b0, r_timer} + {17'd0, i_cfg.tick_ms};
    assign timer_inc = timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];
    assign parts_inc = (r_parts != ccs_pkg::PARTS_MAX) ? r_parts + 16'd1 : r_parts;

    // state registers, updated once per transfer through the core
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ccs_pkg::ST_IDLE;
            r_running  <= 1'b0;
            r_complete <= 1'b0;
            r_fault    <= 1'b0;
            r_code     <= ccs_pkg::FAULT_NONE;
            r_timer    <= '0;
            r_parts    <= '0;
        end else if (i_fire) begin
            r_step     <= n_step;
            r_running  <= n_running;
            r_complete <= n_complete;
            r_fault    <= n_fault;
            r_code     <= n_code;
            r_timer    <= n_timer;
            r_parts    <= n_parts;
        end
    end

    // command decode and step actions
    always_comb begin
        n_step     = r_step;
        n_running  = r_running;
        n_complete = r_complete;
        n_fault    = r_fault;
        n_code     = r_code;
        n_timer    = r_timer;
        n_parts    = r_parts;
        fault_hit  = 1'b0;
        fault_kind = ccs_pkg::FAULT_NONE;
        accepted   = 1'b1;
        lamp_v     = 1'b0;
        lamp_p     = ccs_pkg::LAMP_OFF;
        motor_v    = 1'b0;
        motor_s    = '0;
        clamp_c    = ccs_pkg::CLAMP_NONE;

        unique case (i_item.command)
            ccs_pkg::CMD_TICK: begin
                if (r_running) begin
                    n_timer = timer_inc;
                    unique case (r_step)
                        ccs_pkg::ST_MOTOR_START: begin
                            lamp_v  = 1'b1;
                            lamp_p  = ccs_pkg::LAMP_RUN;
                            motor_v = 1'b1;
                            motor_s = i_cfg.motor_rate;
                            if (i_item.motor_ack_ok) begin
                                n_step  = ccs_pkg::ST_WAIT_SPEED;
                                n_timer = '0;
                            end else begin
                                fault_hit  = 1'b1;
                                fault_kind = ccs_pkg::FAULT_MOTOR;
                            end
                        end
                        ccs_pkg::ST_WAIT_SPEED: begin
                            if (i_item.motor_spun_up) begin
                                n_step  = ccs_pkg::ST_CLAMP_EXTEND;
                                n_timer = '0;
                            end else if (timer_inc > i_cfg.wait_limit_ms) begin
                                fault_hit  = 1'b1;
                                fault_kind = ccs_pkg::FAULT_TIMEOUT;
                            end
                        end
                        ccs_pkg::ST_CLAMP_EXTEND: begin
                            clamp_c = ccs_pkg::CLAMP_EXTEND;
                            if (i_item.clamp_ack_ok) begin
                                lamp_v  = 1'b1;
                                lamp_p  = ccs_pkg::LAMP_PROCESS;
                                n_step  = ccs_pkg::ST_WAIT_EXTEND;
                                n_timer = '0;
                            end else begin
                                fault_hit  = 1'b1;
                                fault_kind = ccs_pkg::FAULT_CLAMP;
                            end
                        end
                        ccs_pkg::ST_WAIT_EXTEND: begin
                            if (i_item.clamp_is_extended) begin
                                n_step  = ccs_pkg::ST_DWELL;
                                n_timer = '0;
                            end else if (timer_inc > i_cfg.wait_limit_ms) begin
                                fault_hit  = 1'b1;
                                fault_kind = ccs_pkg::FAULT_TIMEOUT;
                            end
                        end
                        ccs_pkg::ST_DWELL: begin
                            if (timer_inc >= {16'd0, i_cfg.dwell_ms}) begin
                                n_step  = ccs_pkg::ST_RETRACT;
                                n_timer = '0;
                            end
                        end
                        ccs_pkg::ST_RETRACT: begin
                            clamp_c = ccs_pkg::CLAMP_RETRACT;
                            n_step  = ccs_pkg::ST_WAIT_RETRACT;
                            n_timer = '0;
                        end
                        ccs_pkg::ST_WAIT_RETRACT: begin
                            if (i_item.clamp_is_retracted) begin
                                n_step  = ccs_pkg::ST_COUNT;
                                n_timer = '0;
                            end else if (timer_inc > i_cfg.wait_limit_ms) begin
                                fault_hit  = 1'b1;
                                fault_kind = ccs_pkg::FAULT_TIMEOUT;
                            end
                        end
                        ccs_pkg::ST_COUNT: begin
                            n_parts = parts_inc;
                            if ((i_cfg.parts_goal != 16'd0) &&
                                (parts_inc >= i_cfg.parts_goal)) begin
                                n_complete = 1'b1;
                                n_running  = 1'b0;
                                n_step     = ccs_pkg::ST_IDLE;
                                lamp_v     = 1'b1;
                                lamp_p     = ccs_pkg::LAMP_DONE;
                            end else begin
                                n_step  = ccs_pkg::ST_MOTOR_START;
                                n_timer = '0;
                            end
                        end
                        default: ;
                    endcase

                    // fault overrides the step outcome and the lamp
                    if (fault_hit) begin
                        n_fault   = 1'b1;
                        n_code    = fault_kind;
                        n_running = 1'b0;
                        n_step    = ccs_pkg::ST_IDLE;
                        n_timer   = '0;
                        lamp_v    = 1'b1;
                        lamp_p    = ccs_pkg::LAMP_FAULT;
                    end
                end
            end
            ccs_pkg::CMD_START: begin
                if (r_running) begin
                    accepted = 1'b0;
                end else begin
                    n_running  = 1'b1;
                    n_complete = 1'b0;
                    n_fault    = 1'b0;
                    n_code     = ccs_pkg::FAULT_NONE;
                    n_step     = ccs_pkg::ST_MOTOR_START;
                    n_parts    = '0;
                end
            end
            ccs_pkg::CMD_STOP: begin
                n_running = 1'b0;
                n_step    = ccs_pkg::ST_IDLE;
                motor_v   = 1'b1;
                lamp_v    = 1'b1;
            end
            default: begin
                n_step     = ccs_pkg::ST_IDLE;
                n_running  = 1'b0;
                n_complete = 1'b0;
                n_fault    = 1'b0;
                n_code     = ccs_pkg::FAULT_NONE;
                n_timer    = '0;
                n_parts    = '0;
            end
        endcase
    end

    // status and commands of this transfer
    always_comb begin
        o_result.accepted        = accepted;
        o_result.step_now        = n_step;
        o_result.is_running      = n_running;
        o_result.is_complete     = n_complete;
        o_result.is_faulted      = n_fault;
        o_result.fault_cause     = n_code;
        o_result.parts_done      = n_parts;
        o_result.lamp_valid      = lamp_v;
        o_result.lamp_pattern    = lamp_p;
        o_result.motor_cmd_valid = motor_v;
        o_result.motor_rate_cmd  = motor_s;
        o_result.clamp_cmd       = clamp_c;
    end

`ifndef SYNTHESIS
    // running exactly when the sequence sits on a non-idle step
    a_run_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running == (r_step != ccs_pkg::ST_IDLE))
        else $error("running flag and step disagree");

    // a faulted or completed sequence is never running
    a_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault || r_complete) |-> !r_running)
        else $error("running with fault or complete set");

    // fault cause is set exactly when faulted
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault == (r_code != ccs_pkg::FAULT_NONE))
        else $error("fault flag and fault cause disagree");

    // state only moves on a transfer through the core
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_step) && $stable(r_timer) && $stable(r_parts))
        else $error("state changed without a transfer");
`endif

endmodule

[test/tb_top.sv]
// tb_top: self-checking testbench for the clamp cell step sequencer
// drives commands and register writes, predicts every status transfer and checks it
// depends on ccs_pkg and clamp_cell_step_sequencer
`timescale 1ns / 1ps

module tb_top;

    localparam int PHASES        = 8;
    localparam int PHASE_CMDS    = 250;
    localparam int HOLD_CYCLES   = 48;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 1000;
    localparam int SCRIPT_LEN    = 25;

    // sensor and acknowledge bits in item order
    localparam logic [4:0] NO_SENSE = 5'b00000;
    localparam logic [4:0] S_SPEED  = 5'b10000;
    localparam logic [4:0] S_EXT    = 5'b01000;
    localparam logic [4:0] S_RET    = 5'b00100;
    localparam logic [4:0] S_MACK   = 5'b00010;
    localparam logic [4:0] S_CACK   = 5'b00001;
    localparam logic [4:0] S_ALL    = 5'b11111;

    localparam ccs_pkg::t_cfg CFG_AT_RESET = '{ccs_pkg::RST_STEP_TIMEOUT, ccs_pkg::RST_DWELL,
                                               ccs_pkg::RST_TICK, ccs_pkg::RST_PARTS_GOAL,
                                               ccs_pkg::RST_MOTOR_RATE};

    typedef struct packed {
        ccs_pkg::t_item   cmd;
        logic             typed;
        ccs_pkg::t_result want;
    } t_script_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ccs_pkg::ADDR_W-1:0]  paddr;
    logic [ccs_pkg::DATA_W-1:0]  pwdata;
    logic [ccs_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        i_valid;
    logic                        o_ready;
    logic [1:0]                  i_command;
    logic                        i_motor_spun_up;
    logic                        i_clamp_is_extended;
    logic                        i_clamp_is_retracted;
    logic                        i_motor_ack_ok;
    logic                        i_clamp_ack_ok;
    logic                        o_valid;
    logic                        i_ready;
    logic                        o_accepted;
    logic [3:0]                  o_step_now;
    logic                        o_is_running;
    logic                        o_is_complete;
    logic                        o_is_faulted;
    logic [1:0]                  o_fault_cause;
    logic [15:0]                 o_parts_done;
    logic                        o_lamp_valid;
    logic [9:0]                  o_lamp_pattern;
    logic                        o_motor_cmd_valid;
    logic [15:0]                 o_motor_rate_cmd;
    logic [1:0]                  o_clamp_cmd;

    // sequencer state as the testbench sees it
    ccs_pkg::t_cfg   m_cfg;
    ccs_pkg::t_step  m_step;
    logic            m_running;
    logic            m_complete;
    logic            m_faulted;
    ccs_pkg::t_fault m_fault;
    logic [31:0]     m_timer;
    logic [15:0]     m_parts;

    ccs_pkg::t_result status_due [$];
    t_script_row      script [SCRIPT_LEN];

    int  fail_count;
    int  cmds_sent;
    int  status_checked;
    int  stall_cycles;
    int  send_calm;
    int  recv_calm;
    bit  steady;
    bit  long_hold_req;

    clamp_cell_step_sequencer i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_command            (i_command),
        .i_motor_spun_up      (i_motor_spun_up),
        .i_clamp_is_extended  (i_clamp_is_extended),
        .i_clamp_is_retracted (i_clamp_is_retracted),
        .i_motor_ack_ok       (i_motor_ack_ok),
        .i_clamp_ack_ok       (i_clamp_ack_ok),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_accepted           (o_accepted),
        .o_step_now           (o_step_now),
        .o_is_running         (o_is_running),
        .o_is_complete        (o_is_complete),
        .o_is_faulted         (o_is_faulted),
        .o_fault_cause        (o_fault_cause),
        .o_parts_done         (o_parts_done),
        .o_lamp_valid         (o_lamp_valid),
        .o_lamp_pattern       (o_lamp_pattern),
        .o_motor_cmd_valid    (o_motor_cmd_valid),
        .o_motor_rate_cmd     (o_motor_rate_cmd),
        .o_clamp_cmd          (o_clamp_cmd)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // sequencer prediction
    // ---------------------------------------------------------------

    function automatic void clear_sequence();
        m_step     = ccs_pkg::ST_IDLE;
        m_running  = 1'b0;
        m_complete = 1'b0;
        m_faulted  = 1'b0;
        m_fault    = ccs_pkg::FAULT_NONE;
        m_timer    = '0;
        m_parts    = '0;
    endfunction

    function automatic void move_to(input ccs_pkg::t_step s);
        m_step  = s;
        m_timer = '0;
    endfunction

    // fault lamp replaces any lamp command issued earlier in the same item
    function automatic void trip(input ccs_pkg::t_fault f, inout ccs_pkg::t_result r);
        m_faulted      = 1'b1;
        m_fault        = f;
        m_running      = 1'b0;
        r.lamp_valid   = 1'b1;
        r.lamp_pattern = ccs_pkg::LAMP_FAULT;
        move_to(ccs_pkg::ST_IDLE);
    endfunction

    function automatic ccs_pkg::t_result predict_status(input ccs_pkg::t_item it);
        ccs_pkg::t_result r;
        r = '0;
        r.accepted = 1'b1;
        case (it.command)
            ccs_pkg::CMD_TICK: begin
                if (m_running) begin
                    // step timer saturates rather than wrapping
                    if (m_timer > 32'hFFFF_FFFF - 32'(m_cfg.tick_ms))
                        m_timer = 32'hFFFF_FFFF;
                    else
                        m_timer = m_timer + 32'(m_cfg.tick_ms);
                    case (m_step)
                        ccs_pkg::ST_MOTOR_START: begin
                            r.lamp_valid      = 1'b1;
                            r.lamp_pattern    = ccs_pkg::LAMP_RUN;
                            r.motor_cmd_valid = 1'b1;
                            r.motor_rate_cmd  = m_cfg.motor_rate;
                            if (it.motor_ack_ok)
                                move_to(ccs_pkg::ST_WAIT_SPEED);
                            else
                                trip(ccs_pkg::FAULT_MOTOR, r);
                        end
                        ccs_pkg::ST_WAIT_SPEED: begin
                            if (it.motor_spun_up)
                                move_to(ccs_pkg::ST_CLAMP_EXTEND);
                            if (m_timer > m_cfg.wait_limit_ms)
                                trip(ccs_pkg::FAULT_TIMEOUT, r);
                        end
                        ccs_pkg::ST_CLAMP_EXTEND: begin
                            r.clamp_cmd = ccs_pkg::CLAMP_EXTEND;
                            if (!it.clamp_ack_ok) begin
                                trip(ccs_pkg::FAULT_CLAMP, r);
                            end else begin
                                r.lamp_valid   = 1'b1;
                                r.lamp_pattern = ccs_pkg::LAMP_PROCESS;
                                move_to(ccs_pkg::ST_WAIT_EXTEND);
                            end
                        end
                        ccs_pkg::ST_WAIT_EXTEND: begin
                            if (it.clamp_is_extended)
                                move_to(ccs_pkg::ST_DWELL);
                            if (m_timer > m_cfg.wait_limit_ms)
                                trip(ccs_pkg::FAULT_TIMEOUT, r);
                        end
                        ccs_pkg::ST_DWELL: begin
                            if (m_timer >= 32'(m_cfg.dwell_ms))
                                move_to(ccs_pkg::ST_RETRACT);
                        end
                        ccs_pkg::ST_RETRACT: begin
                            r.clamp_cmd = ccs_pkg::CLAMP_RETRACT;
                            move_to(ccs_pkg::ST_WAIT_RETRACT);
                        end
                        ccs_pkg::ST_WAIT_RETRACT: begin
                            if (it.clamp_is_retracted)
                                move_to(ccs_pkg::ST_COUNT);
                            if (m_timer > m_cfg.wait_limit_ms)
                                trip(ccs_pkg::FAULT_TIMEOUT, r);
                        end
                        ccs_pkg::ST_COUNT: begin
                            if (m_parts != ccs_pkg::PARTS_MAX)
                                m_parts = m_parts + 16'd1;
                            if (m_cfg.parts_goal != 0 && m_parts >= m_cfg.parts_goal) begin
                                m_complete     = 1'b1;
                                m_running      = 1'b0;
                                m_step         = ccs_pkg::ST_IDLE;
                                r.lamp_valid   = 1'b1;
                                r.lamp_pattern = ccs_pkg::LAMP_DONE;
                            end else begin
                                move_to(ccs_pkg::ST_MOTOR_START);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ccs_pkg::CMD_START: begin
                if (m_running) begin
                    r.accepted = 1'b0;
                end else begin
                    m_running  = 1'b1;
                    m_complete = 1'b0;
                    m_faulted  = 1'b0;
                    m_fault    = ccs_pkg::FAULT_NONE;
                    m_step     = ccs_pkg::ST_MOTOR_START;
                    m_parts    = '0;
                end
            end
            ccs_pkg::CMD_STOP: begin
                // fault and complete flags survive a stop
                m_running         = 1'b0;
                m_step            = ccs_pkg::ST_IDLE;
                r.motor_cmd_valid = 1'b1;
                r.motor_rate_cmd  = '0;
                r.lamp_valid      = 1'b1;
                r.lamp_pattern    = ccs_pkg::LAMP_OFF;
            end
            default: clear_sequence();
        endcase
        r.step_now    = m_step;
        r.is_running  = m_running;
        r.is_complete = m_complete;
        r.is_faulted  = m_faulted;
        r.fault_cause = m_fault;
        r.parts_done  = m_parts;
        return r;
    endfunction

    // random command, mostly well-formed runs with the odd noisy item
    function automatic ccs_pkg::t_item pick_cmd(input int luck);
        ccs_pkg::t_item it;
        int             roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            it.command            = ccs_pkg::t_cmd'($urandom_range(0, 3));
            it.motor_spun_up      = 1'($urandom_range(0, 1));
            it.clamp_is_extended  = 1'($urandom_range(0, 1));
            it.clamp_is_retracted = 1'($urandom_range(0, 1));
            it.motor_ack_ok       = 1'($urandom_range(0, 1));
            it.clamp_ack_ok       = 1'($urandom_range(0, 1));
        end else begin
            if (!m_running)
                it.command = (roll < 20) ? ccs_pkg::CMD_TICK :
                             (roll < 23) ? ccs_pkg::CMD_STOP :
                             (roll < 25) ? ccs_pkg::CMD_RESET : ccs_pkg::CMD_START;
            else
                it.command = (roll < 9)  ? ccs_pkg::CMD_STOP :
                             (roll < 10) ? ccs_pkg::CMD_RESET :
                             (roll < 12) ? ccs_pkg::CMD_START : ccs_pkg::CMD_TICK;
            it.motor_spun_up      = $urandom_range(0, 99) < luck;
            it.clamp_is_extended  = $urandom_range(0, 99) < luck;
            it.clamp_is_retracted = $urandom_range(0, 99) < luck;
            it.motor_ack_ok       = $urandom_range(0, 99) < 96;
            it.clamp_ack_ok       = $urandom_range(0, 99) < 96;
        end
        return it;
    endfunction

    // ---------------------------------------------------------------
    // command side
    // ---------------------------------------------------------------

    // entered and left just after a falling edge
    task automatic offer_cmd(input ccs_pkg::t_item it, input logic typed,
                             input ccs_pkg::t_result want);
        ccs_pkg::t_result predicted;
        if (!steady) begin
            if (send_calm > 0) begin
                send_calm--;
            end else if ($urandom_range(0, 59) == 0) begin
                send_calm = $urandom_range(30, 120);
            end else if ($urandom_range(0, 4) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
        end
        i_valid              <= 1'b1;
        i_command            <= it.command;
        i_motor_spun_up      <= it.motor_spun_up;
        i_clamp_is_extended  <= it.clamp_is_extended;
        i_clamp_is_retracted <= it.clamp_is_retracted;
        i_motor_ack_ok       <= it.motor_ack_ok;
        i_clamp_ack_ok       <= it.clamp_ack_ok;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predicted = predict_status(it);
        status_due.push_back(typed ? want : predicted);
        cmds_sent++;
        @(negedge i_clk);
    endtask

    // stop offering until every status has come back
    task automatic wait_all_status();
        i_valid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write all five registers, back-to-back transfers
    task automatic apply_settings(input ccs_pkg::t_cfg c);
        logic [31:0] regval [5];
        regval[ccs_pkg::REG_STEP_TIMEOUT] = c.wait_limit_ms;
        regval[ccs_pkg::REG_DWELL]        = {16'd0, c.dwell_ms};
        regval[ccs_pkg::REG_TICK]         = {16'd0, c.tick_ms};
        regval[ccs_pkg::REG_PARTS_GOAL]   = {16'd0, c.parts_goal};
        regval[ccs_pkg::REG_MOTOR_RATE]   = {16'd0, c.motor_rate};
        for (int k = 0; k < 5; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ccs_pkg::ADDR_W'(k * 4);
            pwdata  <= regval[k];
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready)
                @(posedge i_clk);
            @(negedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        m_cfg = c;
    endtask

    // ---------------------------------------------------------------
    // status side: ready with random bursts of back-pressure
    // ---------------------------------------------------------------

    initial begin
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_ready <= 1'b1;
            end else if (steady || recv_calm > 0) begin
                if (recv_calm > 0)
                    recv_calm--;
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 59) == 0) begin
                recv_calm = $urandom_range(30, 120);
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // status checking and watchdog
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        ccs_pkg::t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (status_due.size() == 0) begin
                    $display("%0t: status transfer with none expected, actual step %0d",
                             $time, o_step_now);
                    fail_count++;
                end else begin
                    want = status_due.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(o_accepted));
                    check_field("step_now", 32'(want.step_now), 32'(o_step_now));
                    check_field("is_running", 32'(want.is_running), 32'(o_is_running));
                    check_field("is_complete", 32'(want.is_complete), 32'(o_is_complete));
                    check_field("is_faulted", 32'(want.is_faulted), 32'(o_is_faulted));
                    check_field("fault_cause", 32'(want.fault_cause), 32'(o_fault_cause));
                    check_field("parts_done", 32'(want.parts_done), 32'(o_parts_done));
                    check_field("lamp_valid", 32'(want.lamp_valid), 32'(o_lamp_valid));
                    check_field("lamp_pattern", 32'(want.lamp_pattern), 32'(o_lamp_pattern));
                    check_field("motor_cmd_valid", 32'(want.motor_cmd_valid),
                                32'(o_motor_cmd_valid));
                    check_field("motor_rate_cmd", 32'(want.motor_rate_cmd),
                                32'(o_motor_rate_cmd));
                    check_field("clamp_cmd", 32'(want.clamp_cmd), 32'(o_clamp_cmd));
                    status_checked++;
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d status pending",
                         $time, stall_cycles, status_due.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        ccs_pkg::t_cfg c;
        int            luck;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        i_valid              = 1'b0;
        i_ready              = 1'b0;
        i_command            = ccs_pkg::CMD_TICK;
        i_motor_spun_up      = 1'b0;
        i_clamp_is_extended  = 1'b0;
        i_clamp_is_retracted = 1'b0;
        i_motor_ack_ok       = 1'b0;
        i_clamp_ack_ok       = 1'b0;
        m_cfg                = CFG_AT_RESET;
        clear_sequence();

        // directed walk: one full part to completion, each fault, stop and reset
        script[0]  = '{{ccs_pkg::CMD_TICK, NO_SENSE}, 1'b1,
                       '{1'b1, ccs_pkg::ST_IDLE, 1'b0, 1'b0, 1'b0,
                         ccs_pkg::FAULT_NONE, 16'd0, 1'b0, ccs_pkg::LAMP_OFF,
                         1'b0, 16'd0, ccs_pkg::CLAMP_NONE}};
        script[1]  = '{{ccs_pkg::CMD_START, NO_SENSE}, 1'b1,
                       '{1'b1, ccs_pkg::ST_MOTOR_START, 1'b1, 1'b0, 1'b0,
                         ccs_pkg::FAULT_NONE, 16'd0, 1'b0, ccs_pkg::LAMP_OFF,
                         1'b0, 16'd0, ccs_pkg::CLAMP_NONE}};
        // start while running is refused
        script[2]  = '{{ccs_pkg::CMD_START, S_ALL}, 1'b1,
                       '{1'b0, ccs_pkg::ST_MOTOR_START, 1'b1, 1'b0, 1'b0,
                         ccs_pkg::FAULT_NONE, 16'd0, 1'b0, ccs_pkg::LAMP_OFF,
                         1'b0, 16'd0, ccs_pkg::CLAMP_NONE}};
        script[3]  = '{{ccs_pkg::CMD_TICK, S_MACK}, 1'b1,
                       '{1'b1, ccs_pkg::ST_WAIT_SPEED, 1'b1, 1'b0, 1'b0,
                         ccs_pkg::FAULT_NONE, 16'd0, 1'b1, ccs_pkg::LAMP_RUN,
                         1'b1, 16'hABCD, ccs_pkg::CLAMP_NONE}};
        script[4]  = '{{ccs_pkg::CMD_TICK, S_SPEED}, 1'b0, '0};
        script[5]  = '{{ccs_pkg::CMD_TICK, S_CACK}, 1'b0, '0};
        script[6]  = '{{ccs_pkg::CMD_TICK, S_EXT}, 1'b0, '0};
        script[7]  = '{{ccs_pkg::CMD_TICK, NO_SENSE}, 1'b0, '0};
        script[8]  = '{{ccs_pkg::CMD_TICK, NO_SENSE}, 1'b0, '0};
        script[9]  = '{{ccs_pkg::CMD_TICK, NO_SENSE}, 1'b0, '0};
        script[10] = '{{ccs_pkg::CMD_TICK, S_RET}, 1'b0, '0};
        // target of one part reached
        script[11] = '{{ccs_pkg::CMD_TICK, NO_SENSE}, 1'b1,
                       '{1'b1, ccs_pkg::ST_IDLE, 1'b0, 1'b1, 1'b0,
                         ccs_pkg::FAULT_NONE, 16'd1, 1'b1, ccs_pkg::LAMP_DONE,
                         1'b0, 16'd0, ccs_pkg::CLAMP_NONE}};
        script[12] = '{{ccs_pkg::CMD_START, NO_SENSE}, 1'b0, '0};
        // motor refuses: run lamp and speed command, then the fault lamp wins
        script[13] = '{{ccs_pkg::CMD_TICK, NO_SENSE}, 1'b1,
                       '{1'b1, ccs_pkg::ST_IDLE, 1'b0, 1'b0, 1'b1,
                         ccs_pkg::FAULT_MOTOR, 16'd0, 1'b1, ccs_pkg::LAMP_FAULT,
                         1'b1, 16'hABCD, ccs_pkg::CLAMP_NONE}};
        script[14] = '{{ccs_pkg::CMD_START, NO_SENSE}, 1'b0, '0};
        script[15] = '{{ccs_pkg::CMD_TICK, S_MACK}, 1'b0, '0};
        script[16] = '{{ccs_pkg::CMD_TICK, NO_SENSE}, 1'b0, '0};
        // waiting for speed runs past the step timeout
        script[17] = '{{ccs_pkg::CMD_TICK, NO_SENSE}, 1'b1,
                       '{1'b1, ccs_pkg::ST_IDLE, 1'b0, 1'b0, 1'b1,
                         ccs_pkg::FAULT_TIMEOUT, 16'd0, 1'b1, ccs_pkg::LAMP_FAULT,
                         1'b0, 16'd0, ccs_pkg::CLAMP_NONE}};
        script[18] = '{{ccs_pkg::CMD_START, NO_SENSE}, 1'b0, '0};
        script[19] = '{{ccs_pkg::CMD_TICK, S_MACK}, 1'b0, '0};
        script[20] = '{{ccs_pkg::CMD_TICK, S_SPEED}, 1'b0, '0};
        // clamp refuses the extend
        script[21] = '{{ccs_pkg::CMD_TICK, S_MACK}, 1'b1,
                       '{1'b1, ccs_pkg::ST_IDLE, 1'b0, 1'b0, 1'b1,
                         ccs_pkg::FAULT_CLAMP, 16'd0, 1'b1, ccs_pkg::LAMP_FAULT,
                         1'b0, 16'd0, ccs_pkg::CLAMP_EXTEND}};
        script[22] = '{{ccs_pkg::CMD_STOP, NO_SENSE}, 1'b1,
                       '{1'b1, ccs_pkg::ST_IDLE, 1'b0, 1'b0, 1'b1,
                         ccs_pkg::FAULT_CLAMP, 16'd0, 1'b1, ccs_pkg::LAMP_OFF,
                         1'b1, 16'd0, ccs_pkg::CLAMP_NONE}};
        script[23] = '{{ccs_pkg::CMD_START, NO_SENSE}, 1'b0, '0};
        script[24] = '{{ccs_pkg::CMD_RESET, S_ALL}, 1'b1,
                       '{1'b1, ccs_pkg::ST_IDLE, 1'b0, 1'b0, 1'b0,
                         ccs_pkg::FAULT_NONE, 16'd0, 1'b0, ccs_pkg::LAMP_OFF,
                         1'b0, 16'd0, ccs_pkg::CLAMP_NONE}};

        // hold the synchronous reset, then release it after a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apply_settings('{32'd150, 16'd200, 16'd100, 16'd1, 16'hABCD});
        for (int n = 0; n < SCRIPT_LEN; n++)
            offer_cmd(script[n].cmd, script[n].typed, script[n].want);
        wait_all_status();

        // random phases over a spread of settings, reset values and extremes first
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: c = CFG_AT_RESET;
                1: c = '{32'd0, 16'd0, 16'd1, 16'd1, 16'd0};
                2: c = '{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                // zero tick: the step timer stands still
                3: c = '{32'($urandom_range(0, 800)), 16'd0, 16'd0,
                         16'($urandom_range(0, 3)), 16'($urandom)};
                default: c = '{($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000)),
                               16'($urandom_range(0, 600)), 16'($urandom_range(1, 400)),
                               16'($urandom_range(0, 4)), 16'($urandom)};
            endcase
            luck = $urandom_range(30, 90);
            apply_settings(c);
            // long status hold-off while commands keep coming
            if (phase == 2) begin
                send_calm     = 80;
                long_hold_req = 1'b1;
            end
            // no idling in the last phase
            if (phase == PHASES - 1)
                steady = 1'b1;
            for (int n = 0; n < PHASE_CMDS; n++)
                offer_cmd(pick_cmd(luck), 1'b0, '0);
            wait_all_status();
        end

        $display("covered %0d commands, %0d status transfers checked, %0d register settings",
                 cmds_sent, status_checked, PHASES + 1);
        $display("incl. every step and fault, refused start, stop and reset, output stalls");
        if (fail_count == 0 && status_due.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ccs_pkg.sv
rtl/ccs_cfg_regs.sv
rtl/ccs_step_core.sv
rtl/clamp_cell_step_sequencer.sv
test/tb_top.sv
